// ----- sv/itp_pkg.sv -----
// Shared types, character constants and operator code helpers for the
// infix to postfix converter. No dependencies.
package itp_pkg;

  // Default operator stack depth
  localparam int STACK_DEPTH_DEF = 32;

  // Stacked operator code
  typedef logic [2:0] code_t;

  // Operator codes held in the stack cells
  localparam code_t CODE_PLUS  = 3'd0;
  localparam code_t CODE_MINUS = 3'd1;
  localparam code_t CODE_STAR  = 3'd2;
  localparam code_t CODE_SLASH = 3'd3;
  localparam code_t CODE_LPAR  = 3'd4;

  // Input characters with a special meaning
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LPAR  = 8'h28;
  localparam logic [7:0] CHAR_RPAR  = 8'h29;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Shift control for the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  // Priority: '(' binds weakest so it stops every operator pop run
  function automatic logic [1:0] code_prio(input code_t code);
    logic [1:0] p;
    case (code)
      CODE_PLUS, CODE_MINUS: p = 2'd1;
      CODE_STAR, CODE_SLASH: p = 2'd2;
      default:               p = 2'd0;
    endcase
    return p;
  endfunction

  // Character that a stacked code is emitted as
  function automatic logic [7:0] code_char(input code_t code);
    logic [7:0] c;
    case (code)
      CODE_PLUS:  c = CHAR_PLUS;
      CODE_MINUS: c = CHAR_MINUS;
      CODE_STAR:  c = CHAR_STAR;
      CODE_SLASH: c = CHAR_SLASH;
      default:    c = CHAR_LPAR;
    endcase
    return c;
  endfunction

  // Operator character to its code
  function automatic code_t sym_code(input logic [7:0] sym);
    code_t c;
    case (sym)
      CHAR_PLUS:  c = CODE_PLUS;
      CHAR_MINUS: c = CODE_MINUS;
      CHAR_STAR:  c = CODE_STAR;
      CHAR_SLASH: c = CODE_SLASH;
      default:    c = CODE_LPAR;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/itp_stack_cell.sv -----
// One entry of the shifting operator stack. Takes the neighbor above on a
// push and the neighbor below on a pop. Depends on itp_pkg.
module itp_stack_cell (
  input  logic              clk,
  input  itp_pkg::stk_ctrl_t ctrl,
  input  itp_pkg::code_t    from_above,
  input  itp_pkg::code_t    from_below,
  output itp_pkg::code_t    code
);
  import itp_pkg::*;

  // Entry register, shifted toward the bottom on push, toward the top on pop
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      code <= from_above;
    end else if (ctrl.pop) begin
      code <= from_below;
    end
  end

endmodule

// ----- sv/infix_to_postfix_converter.sv -----
// Top level of the infix to postfix converter: control sequencer, output
// register and a chain of itp_stack_cell entries. Depends on itp_pkg.
//
//  channel | dir | fields
//  --------+-----+--------------------------------------------------
//  s_      | in  | tdata[7:0] symbol
//  m_      | out | tdata[7:0] out_symbol, tlast last, tuser error
//
// An accepted symbol is registered, then worked off as one stack pop, push
// or result per work step; the final step of ')' runs even with no '(' to
// discard, and an end also spends a step on each stray '('. The sequencer
// does one stack shift per cycle unless a stalled m_ side holds it.
// rst is synchronous: it empties the stack and clears the error flag.
// A stalled m_ side holds the sequencer; s_tready is low while busy.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_symbol
  output logic       m_tlast,
  output logic       m_tuser    // [0] error
);
  import itp_pkg::*;

  localparam int CountW = $clog2(STACK_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic              state, state_next;
  logic [7:0]        sym;
  logic [CountW-1:0] count;
  logic              err_seen;

  stk_ctrl_t         ctrl;
  code_t             push_code;
  code_t             cell_code [STACK_DEPTH];

  logic              out_free;
  logic              emit, emit_last, emit_err;
  logic [7:0]        emit_sym;
  logic              err_set, err_clr;

  logic              count_nz, count_gt1, count_full;
  code_t             top, second, op;

  assign s_tready   = (state == S_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign top        = cell_code[0];
  assign second     = cell_code[1];
  assign op         = sym_code(sym);
  assign count_nz   = (count != '0);
  assign count_gt1  = (count > CountW'(1));
  assign count_full = (count == CountW'(STACK_DEPTH));

  // Sequencer: one pop, push or result per cycle unless a stalled m_ side holds it
  always_comb begin
    state_next = state;
    ctrl       = '0;
    push_code  = CODE_LPAR;
    emit       = 1'b0;
    emit_sym   = sym;
    emit_last  = 1'b0;
    emit_err   = 1'b0;
    err_set    = 1'b0;
    err_clr    = 1'b0;
    if (state == S_IDLE) begin
      if (s_tvalid) state_next = S_WORK;
    end else begin
      case (sym)
        CHAR_NUL: begin
          if (count_nz) begin
            if (top == CODE_LPAR) begin
              ctrl.pop = 1'b1;
              err_set  = 1'b1;
            end else if (out_free) begin
              emit     = 1'b1;
              emit_sym = code_char(top);
              ctrl.pop = 1'b1;
            end
          end else if (out_free) begin
            emit       = 1'b1;
            emit_sym   = CHAR_NUL;
            emit_err   = err_seen;
            emit_last  = 1'b1;
            err_clr    = 1'b1;
            state_next = S_IDLE;
          end
        end
        CHAR_LPAR: begin
          push_code  = CODE_LPAR;
          ctrl.push  = !count_full;
          err_set    = count_full;
          state_next = S_IDLE;
        end
        CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH: begin
          if (count_nz && code_prio(top) >= code_prio(op)) begin
            if (out_free) begin
              emit      = 1'b1;
              emit_sym  = code_char(top);
              emit_last = !(count_gt1 && code_prio(second) >= code_prio(op));
              ctrl.pop  = 1'b1;
            end
          end else begin
            push_code  = op;
            ctrl.push  = !count_full;
            err_set    = count_full;
            state_next = S_IDLE;
          end
        end
        CHAR_RPAR: begin
          if (count_nz && top != CODE_LPAR) begin
            if (out_free) begin
              emit      = 1'b1;
              emit_sym  = code_char(top);
              emit_last = !(count_gt1 && second != CODE_LPAR);
              ctrl.pop  = 1'b1;
            end
          end else begin
            ctrl.pop   = count_nz;
            err_set    = !count_nz;
            state_next = S_IDLE;
          end
        end
        default: begin
          if (out_free) begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            state_next = S_IDLE;
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      err_seen <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.push) begin
        count <= count + CountW'(1);
      end else if (ctrl.pop) begin
        count <= count - CountW'(1);
      end
      if (err_clr) begin
        err_seen <= 1'b0;
      end else if (err_set) begin
        err_seen <= 1'b1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Input symbol and output payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sym <= s_tdata;
    end
    if (emit) begin
      m_tdata <= emit_sym;
      m_tlast <= emit_last;
      m_tuser <= emit_err;
    end
  end

  // Operator stack as a chain of shifting cells, entry 0 on top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    code_t above, below;
    if (i == 0) begin : g_top
      assign above = push_code;
    end else begin : g_mid
      assign above = cell_code[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_code[i];
    end else begin : g_nxt
      assign below = cell_code[i+1];
    end
    itp_stack_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .code       (cell_code[i])
    );
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && ctrl.pop))
    else $error("push and pop in one cycle");

  a_err_on_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == CHAR_NUL && m_tlast)
    else $error("error flag outside end marker");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted twice without work cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !emit)
    else $error("result overwritten while stalled");

endmodule

// ----- tb/sv/tb_infix_to_postfix_converter.sv -----
// Self-checking testbench for infix_to_postfix_converter: a shunting-yard
// predictor, a queued stream driver and a checking monitor with random stalls.
// Depends on itp_pkg and the infix_to_postfix_converter RTL.
module tb_infix_to_postfix_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int DEPTH    = STACK_DEPTH_DEF;
  localparam int HOLD_AT  = 600;  // cycle after reset where the long output hold starts
  localparam int HOLD_LEN = 300;

  // One queued input symbol and the idle cycles in front of it
  typedef struct {
    logic [7:0] sym;
    int         gap;
  } sym_item_t;

  // One postfix output transfer
  typedef struct {
    logic [7:0] sym;
    logic       last;
    logic       err;
  } postfix_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] symbol
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_symbol
  logic       m_tlast;
  logic       m_tuser;           // [0] error

  sym_item_t  pend[$];
  postfix_t   postfix_q[$];
  logic [7:0] op_chars[4] = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};

  // Predictor state
  code_t       op_stk[DEPTH];
  int unsigned stk_cnt = 0;
  bit          flag_err = 1'b0;

  int  wait_cnt = 0;
  int  rx_wait = 0;
  bit  tx_fast = 1'b0;
  bit  rx_fast = 1'b0;
  bit  hold_off = 1'b0;
  int  tick = 0;
  int  errors = 0;
  int  n_in = 0;
  int  n_out = 0;
  int  n_ends = 0;
  int  n_flagged = 0;
  int  n_overflow = 0;

  infix_to_postfix_converter #(.STACK_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic int op_rank(input code_t c);
    if (c == CODE_PLUS || c == CODE_MINUS) return 1;
    if (c == CODE_STAR || c == CODE_SLASH) return 2;
    return 0;
  endfunction

  function automatic logic [7:0] op_glyph(input code_t c);
    case (c)
      CODE_PLUS:  return CHAR_PLUS;
      CODE_MINUS: return CHAR_MINUS;
      CODE_STAR:  return CHAR_STAR;
      default:    return CHAR_SLASH;
    endcase
  endfunction

  // Full stack drops the push and marks the expression bad
  function automatic void push_op(input code_t c);
    if (stk_cnt < DEPTH) begin
      op_stk[stk_cnt] = c;
      stk_cnt++;
    end else begin
      flag_err = 1'b1;
      n_overflow++;
    end
  endfunction

  // Work out the postfix transfers one accepted symbol causes
  function automatic void shunt_symbol(input logic [7:0] sym);
    postfix_t res[$];
    code_t    c;
    case (sym)
      CHAR_NUL: begin
        // flush: stray '(' are dropped and flagged, then the end marker
        while (stk_cnt > 0) begin
          c = op_stk[stk_cnt - 1];
          stk_cnt--;
          if (c == CODE_LPAR) flag_err = 1'b1;
          else res.push_back(postfix_t'{sym: op_glyph(c), last: 1'b0, err: 1'b0});
        end
        res.push_back(postfix_t'{sym: CHAR_NUL, last: 1'b0, err: flag_err});
        n_ends++;
        if (flag_err) n_flagged++;
        flag_err = 1'b0;
      end
      CHAR_LPAR: push_op(CODE_LPAR);
      CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH: begin
        c = (sym == CHAR_PLUS)  ? CODE_PLUS  :
            (sym == CHAR_MINUS) ? CODE_MINUS :
            (sym == CHAR_STAR)  ? CODE_STAR  : CODE_SLASH;
        while (stk_cnt > 0 && op_rank(op_stk[stk_cnt - 1]) >= op_rank(c)) begin
          res.push_back(postfix_t'{sym: op_glyph(op_stk[stk_cnt - 1]), last: 1'b0,
                                   err: 1'b0});
          stk_cnt--;
        end
        push_op(c);
      end
      CHAR_RPAR: begin
        while (stk_cnt > 0 && op_stk[stk_cnt - 1] != CODE_LPAR) begin
          res.push_back(postfix_t'{sym: op_glyph(op_stk[stk_cnt - 1]), last: 1'b0,
                                   err: 1'b0});
          stk_cnt--;
        end
        // unmatched ')' stops at the empty stack
        if (stk_cnt > 0) stk_cnt--;
        else flag_err = 1'b1;
      end
      default: res.push_back(postfix_t'{sym: sym, last: 1'b0, err: 1'b0});
    endcase
    if (res.size() != 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) postfix_q.push_back(res[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic add_sym(input logic [7:0] s);
    if ($urandom_range(0, 29) == 0) tx_fast = ~tx_fast;
    pend.push_back('{sym: s, gap: tx_fast ? 0 : int'($urandom_range(0, 6))});
  endtask

  // Any character that is neither an operator, a parenthesis nor the end byte
  function automatic logic [7:0] pick_operand();
    logic [7:0] v;
    if ($urandom_range(0, 1) == 1) return 8'h61 + 8'($urandom_range(0, 25));
    do
      v = 8'($urandom_range(1, 255));
    while (v == CHAR_LPAR || v == CHAR_RPAR || v == CHAR_STAR || v == CHAR_PLUS ||
           v == CHAR_MINUS || v == CHAR_SLASH);
    return v;
  endfunction

  // Well-formed expression with random operands, operators and nesting
  task automatic add_expr();
    int depth;
    int n;
    depth = 0;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      while ($urandom_range(0, 3) == 0 && depth < 6) begin
        add_sym(CHAR_LPAR);
        depth++;
      end
      add_sym(pick_operand());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        add_sym(CHAR_RPAR);
        depth--;
      end
      if (k < n - 1) add_sym(op_chars[$urandom_range(0, 3)]);
    end
    for (int k = 0; k < depth; k++) add_sym(CHAR_RPAR);
    add_sym(CHAR_NUL);
  endtask

  // Nesting deep enough to run into the stack limit
  task automatic add_deep(input int levels);
    for (int k = 0; k < levels; k++) begin
      add_sym(CHAR_LPAR);
      if ($urandom_range(0, 3) == 0) begin
        add_sym(pick_operand());
        add_sym(op_chars[$urandom_range(0, 3)]);
      end
    end
    repeat ($urandom_range(0, 4)) add_sym(CHAR_RPAR);
    add_sym(pick_operand());
    add_sym(CHAR_NUL);
  endtask

  // Token soup: stray parentheses, doubled operators, sometimes no end byte
  task automatic add_broken();
    int r;
    repeat ($urandom_range(2, 10)) begin
      r = $urandom_range(0, 5);
      case (r)
        0:       add_sym(CHAR_LPAR);
        1:       add_sym(CHAR_RPAR);
        2:       add_sym(op_chars[$urandom_range(0, 3)]);
        default: add_sym(pick_operand());
      endcase
    end
    if ($urandom_range(0, 3) != 0) add_sym(CHAR_NUL);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      wait_cnt <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        shunt_symbol(s_tdata);
        n_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pend.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (wait_cnt < pend[0].gap) begin
          wait_cnt <= wait_cnt + 1;
          s_tvalid <= 1'b0;
        end else begin
          s_tdata  <= pend[0].sym;
          s_tvalid <= 1'b1;
          wait_cnt <= 0;
          void'(pend.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    postfix_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (postfix_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer: expected none, actual sym=%h last=%b err=%b",
                   $time, m_tdata, m_tlast, m_tuser);
        end else begin
          want = postfix_q.pop_front();
          if (m_tdata !== want.sym) begin
            errors++;
            $display("%0t: out_symbol mismatch: expected %h, actual %h",
                     $time, want.sym, m_tdata);
          end
          if (m_tlast !== want.last) begin
            errors++;
            $display("%0t: last mismatch (sym %h): expected %b, actual %b",
                     $time, want.sym, want.last, m_tlast);
          end
          if (m_tuser !== want.err) begin
            errors++;
            $display("%0t: error flag mismatch (sym %h): expected %b, actual %b",
                     $time, want.sym, want.err, m_tuser);
          end
        end
        if ($urandom_range(0, 24) == 0) rx_fast = ~rx_fast;
        rx_wait = rx_fast ? 0 : $urandom_range(0, 6);
      end
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering symbols
  always @(posedge clk) begin
    if (rst) begin
      tick     <= 0;
      hold_off <= 1'b0;
    end else begin
      tick     <= tick + 1;
      hold_off <= (tick >= HOLD_AT) && (tick < HOLD_AT + HOLD_LEN);
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int r;
    // directed: byte extremes, all operators, parentheses
    add_sym(8'hFF); add_sym(CHAR_PLUS); add_sym(8'h01); add_sym(CHAR_STAR);
    add_sym(CHAR_LPAR); add_sym(8'h80); add_sym(CHAR_MINUS); add_sym(8'h7F);
    add_sym(CHAR_RPAR); add_sym(CHAR_SLASH); add_sym(8'h55); add_sym(CHAR_NUL);
    // unmatched ')'
    add_sym(CHAR_RPAR); add_sym(8'hAA); add_sym(CHAR_NUL);
    // unmatched '(' left at the end
    add_sym(CHAR_LPAR); add_sym(CHAR_LPAR); add_sym(8'h41); add_sym(CHAR_RPAR);
    add_sym(CHAR_MINUS); add_sym(CHAR_NUL);
    // empty expression
    add_sym(CHAR_NUL);

    // random: one guaranteed stack overflow, then a mix weighted to good input
    add_deep(36);
    while (pend.size() < 375) begin
      r = $urandom_range(0, 39);
      if (r == 0) add_deep($urandom_range(28, 38));
      else if (r <= 5) repeat ($urandom_range(1, 6)) add_sym(8'($urandom_range(0, 255)));
      else if (r <= 11) add_broken();
      else add_expr();
    end
    add_sym(CHAR_NUL);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (pend.size() != 0 || s_tvalid);
    while (postfix_q.size() != 0) @(negedge clk);
    repeat (DEPTH + 10) @(negedge clk);

    $display("run: %0d symbols in, %0d postfix transfers checked, %0d expressions closed",
             n_in, n_out, n_ends);
    $display("run: %0d expressions flagged bad, %0d dropped pushes on a full stack",
             n_flagged, n_overflow);
    if (errors == 0) begin
      $display("tb_infix_to_postfix_converter: clean");
    end else begin
      $display("tb_infix_to_postfix_converter: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_infix_to_postfix_converter: errors");
    $finish;
  end

endmodule

// ----- infix_to_postfix_converter.f -----
sv/itp_pkg.sv
sv/itp_stack_cell.sv
sv/infix_to_postfix_converter.sv
tb/sv/tb_infix_to_postfix_converter.sv
